// File: hw/rtl/stl_pkg.sv
// shared types, constants and byte classifiers for the source text lexer
// no dependencies; used by stl_core, stl_fifo and source_text_lexer_top
package stl_pkg;

    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = PTR_W + 1;
    localparam int MAX_RECS   = 3;

    typedef logic [2:0] kind_t;

    localparam kind_t KIND_END      = 3'd0;
    localparam kind_t KIND_STRING   = 3'd1;
    localparam kind_t KIND_NUMBER   = 3'd2;
    localparam kind_t KIND_OPERATOR = 3'd3;
    localparam kind_t KIND_PUNCT    = 3'd4;
    localparam kind_t KIND_KEYWORD  = 3'd5;
    localparam kind_t KIND_IDENT    = 3'd6;

    localparam logic REC_VALUE = 1'b0;
    localparam logic REC_CLOSE = 1'b1;

    localparam logic [7:0] BYTE_SPACE     = 8'h20;
    localparam logic [7:0] BYTE_QUOTE     = 8'h22;
    localparam logic [7:0] BYTE_BACKSLASH = 8'h5C;
    localparam logic [7:0] BYTE_DOT       = 8'h2E;

    typedef struct packed {
        logic       rec_kind;
        logic [7:0] value;
        kind_t      kind;
        logic       last;
    } rec_t;

    // records handed from the core to the output buffer in one cycle
    typedef struct packed {
        logic [1:0]            count;
        rec_t [MAX_RECS-1:0]   recs;
    } rec_bundle_t;

    function automatic logic is_number_byte(input logic [7:0] b);
        return (b inside {[8'h30:8'h39]}) || (b == BYTE_DOT);
    endfunction

    function automatic logic is_op_byte(input logic [7:0] b);
        return b inside {8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h25, 8'h5E,
                         8'h26, 8'h7C, 8'h21, 8'h3E, 8'h3C, 8'h3D};
    endfunction

    function automatic logic is_punct_byte(input logic [7:0] b);
        return b inside {8'h28, 8'h29, 8'h7B, 8'h7D, 8'h2C, 8'h3B};
    endfunction

    function automatic logic is_ident_byte(input logic [7:0] b);
        return (b != BYTE_SPACE) && (b != BYTE_QUOTE) && !is_number_byte(b)
               && !is_op_byte(b) && !is_punct_byte(b);
    endfunction

    // keyword lengths: if, event, true, false
    function automatic logic [2:0] kw_len(input logic [1:0] k);
        logic [2:0] r;
        case (k)
            2'd0:    r = 3'd2;
            2'd1:    r = 3'd5;
            2'd2:    r = 3'd4;
            default: r = 3'd5;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
        logic [7:0] r;
        r = 8'h00;
        case ({k, pos})
            {2'd0, 3'd0}: r = "i";
            {2'd0, 3'd1}: r = "f";
            {2'd1, 3'd0}: r = "e";
            {2'd1, 3'd1}: r = "v";
            {2'd1, 3'd2}: r = "e";
            {2'd1, 3'd3}: r = "n";
            {2'd1, 3'd4}: r = "t";
            {2'd2, 3'd0}: r = "t";
            {2'd2, 3'd1}: r = "r";
            {2'd2, 3'd2}: r = "u";
            {2'd2, 3'd3}: r = "e";
            {2'd3, 3'd0}: r = "f";
            {2'd3, 3'd1}: r = "a";
            {2'd3, 3'd2}: r = "l";
            {2'd3, 3'd3}: r = "s";
            {2'd3, 3'd4}: r = "e";
            default:      r = 8'h00;
        endcase
        return r;
    endfunction

    // narrow the keyword candidates by one more identifier byte
    function automatic logic [3:0] kw_feed(input logic [3:0] cand, input logic [2:0] len,
                                           input logic [7:0] b);
        logic [3:0] r;
        r = 4'd0;
        for (int i = 0; i < 4; i++)
        begin
            r[i] = cand[i] && (len < kw_len(2'(i))) && (kw_char(2'(i), len) == b);
        end
        return r;
    endfunction

    function automatic kind_t ident_kind(input logic [3:0] cand, input logic [2:0] len);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            hit = hit | (cand[i] && (len == kw_len(2'(i))));
        end
        return hit ? KIND_KEYWORD : KIND_IDENT;
    endfunction

endpackage

// File: hw/rtl/source_text_lexer_top.sv
// source text lexer: one text byte per transfer in, token records out
// records of an item are built from the input register and written into the buffer
// before they are offered; without room the item waits in that register
// throughput: one item per cycle while there is room; one record per cycle leaves
// the 8-entry buffer unless out_stall; items causing two or three records are
// absorbed by that buffer, input stalls when fewer than three entries are free
// reset: rst_n asynchronous active low, clears lexer state and empties the buffer
module source_text_lexer_top (
    input  logic       clk,
    input  logic       rst_n,
    // input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] text_byte,
    input  logic       end_of_text,
    // output channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic       record_kind,
    output logic [7:0] value_byte,
    output logic [2:0] token_kind,
    output logic       last_of_run
);

    // records written by the core this cycle
    stl_pkg::rec_bundle_t wr;
    // buffer can take a full burst
    logic room;
    // oldest record in the buffer
    stl_pkg::rec_t head;

    // input register, lexer state and record generation
    stl_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .room        (room),
        .wr          (wr)
    );

    // output buffer, one record per transfer
    stl_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    // record fields straight from the buffer head
    assign record_kind = head.rec_kind;
    assign value_byte  = head.value;
    assign token_kind  = head.kind;
    assign last_of_run = head.last;

endmodule

// File: hw/rtl/stl_core.sv
// lexer core: input register, lexer state and one-pass record generation
// depends on stl_pkg
module stl_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          text_byte,
    input  logic                end_of_text,
    input  logic                room,
    output stl_pkg::rec_bundle_t wr
);

    typedef enum logic [2:0] {
        MODE_IDLE     = 3'd0,
        MODE_STRING   = 3'd1,
        MODE_ESCAPE   = 3'd2,
        MODE_NUMBER   = 3'd3,
        MODE_OPERATOR = 3'd4,
        MODE_IDENT    = 3'd5
    } mode_t;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  byte_reg;
    logic        eot_reg;
    mode_t       mode_reg, mode_next;
    logic [3:0]  cand_reg, cand_next;
    logic [2:0]  len_reg, len_next;

    logic        fire;
    logic        accept;
    logic        close_en, value_en, start_en;
    stl_pkg::kind_t value_kind, close_kind;
    stl_pkg::rec_t [stl_pkg::MAX_RECS-1:0] recs;
    logic [1:0]  n;
    logic [7:0]  b;

    assign fire     = in_valid_reg && room;
    assign in_stall = in_valid_reg && !room;
    assign accept   = in_valid && !in_stall;
    assign b        = byte_reg;

    always_comb
    begin
        case (mode_reg)
            MODE_STRING, MODE_ESCAPE: close_kind = stl_pkg::KIND_STRING;
            MODE_NUMBER:              close_kind = stl_pkg::KIND_NUMBER;
            MODE_OPERATOR:            close_kind = stl_pkg::KIND_OPERATOR;
            MODE_IDENT:               close_kind = stl_pkg::ident_kind(cand_reg, len_reg);
            default:                  close_kind = stl_pkg::KIND_END;
        endcase
    end

    always_comb
    begin
        mode_next  = mode_reg;
        cand_next  = cand_reg;
        len_next   = len_reg;
        close_en   = 1'b0;
        value_en   = 1'b0;
        start_en   = 1'b0;
        value_kind = stl_pkg::KIND_STRING;
        n          = 2'd0;
        recs       = '0;

        // decide what the byte does to the open token
        if (eot_reg)
        begin
            close_en = (mode_reg != MODE_IDLE);
        end
        else
        begin
            case (mode_reg)
                MODE_STRING:
                begin
                    if (b == stl_pkg::BYTE_BACKSLASH)
                        mode_next = MODE_ESCAPE;
                    else if (b == stl_pkg::BYTE_QUOTE)
                        close_en = 1'b1;
                    else
                        value_en = 1'b1;
                end
                MODE_ESCAPE:
                begin
                    value_en  = 1'b1;
                    mode_next = MODE_STRING;
                end
                MODE_NUMBER:
                begin
                    value_kind = stl_pkg::KIND_NUMBER;
                    value_en   = stl_pkg::is_number_byte(b);
                    close_en   = !value_en;
                    start_en   = !value_en;
                end
                MODE_OPERATOR:
                begin
                    value_kind = stl_pkg::KIND_OPERATOR;
                    value_en   = stl_pkg::is_op_byte(b);
                    close_en   = !value_en;
                    start_en   = !value_en;
                end
                MODE_IDENT:
                begin
                    value_kind = stl_pkg::KIND_IDENT;
                    value_en   = stl_pkg::is_ident_byte(b) || stl_pkg::is_number_byte(b);
                    close_en   = !value_en;
                    start_en   = !value_en;
                    if (value_en)
                    begin
                        cand_next = stl_pkg::kw_feed(cand_reg, len_reg, b);
                        len_next  = (len_reg == 3'd7) ? 3'd7 : len_reg + 3'd1;
                    end
                end
                default:
                begin
                    start_en = 1'b1;
                end
            endcase
        end

        if (close_en)
        begin
            recs[n] = '{rec_kind: stl_pkg::REC_CLOSE, value: 8'h00, kind: close_kind,
                        last: 1'b0};
            n         = n + 2'd1;
            mode_next = MODE_IDLE;
            cand_next = 4'd0;
            len_next  = 3'd0;
        end

        if (value_en)
        begin
            recs[n] = '{rec_kind: stl_pkg::REC_VALUE, value: b, kind: value_kind, last: 1'b0};
            n       = n + 2'd1;
        end

        if (start_en && (b != stl_pkg::BYTE_SPACE))
        begin
            if (b == stl_pkg::BYTE_QUOTE)
            begin
                mode_next = MODE_STRING;
            end
            else if (stl_pkg::is_number_byte(b))
            begin
                recs[n] = '{rec_kind: stl_pkg::REC_VALUE, value: b,
                            kind: stl_pkg::KIND_NUMBER, last: 1'b0};
                n         = n + 2'd1;
                mode_next = MODE_NUMBER;
            end
            else if (stl_pkg::is_ident_byte(b))
            begin
                recs[n] = '{rec_kind: stl_pkg::REC_VALUE, value: b,
                            kind: stl_pkg::KIND_IDENT, last: 1'b0};
                n         = n + 2'd1;
                mode_next = MODE_IDENT;
                cand_next = stl_pkg::kw_feed(4'hF, 3'd0, b);
                len_next  = 3'd1;
            end
            else if (stl_pkg::is_punct_byte(b))
            begin
                recs[n] = '{rec_kind: stl_pkg::REC_VALUE, value: b,
                            kind: stl_pkg::KIND_PUNCT, last: 1'b0};
                n       = n + 2'd1;
                recs[n] = '{rec_kind: stl_pkg::REC_CLOSE, value: 8'h00,
                            kind: stl_pkg::KIND_PUNCT, last: 1'b0};
                n       = n + 2'd1;
            end
            else
            begin
                recs[n] = '{rec_kind: stl_pkg::REC_VALUE, value: b,
                            kind: stl_pkg::KIND_OPERATOR, last: 1'b0};
                n         = n + 2'd1;
                mode_next = MODE_OPERATOR;
            end
        end

        if (eot_reg)
        begin
            recs[n] = '{rec_kind: stl_pkg::REC_CLOSE, value: 8'h00,
                        kind: stl_pkg::KIND_END, last: 1'b0};
            n         = n + 2'd1;
            mode_next = MODE_IDLE;
            cand_next = 4'd0;
            len_next  = 3'd0;
        end

        if (n != 2'd0)
            recs[n - 2'd1].last = 1'b1;
    end

    assign wr.count = fire ? n : 2'd0;
    assign wr.recs  = recs;

    always_comb
    begin
        if (accept)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            mode_reg     <= MODE_IDLE;
            cand_reg     <= 4'd0;
            len_reg      <= 3'd0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (fire)
            begin
                mode_reg <= mode_next;
                cand_reg <= cand_next;
                len_reg  <= len_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= text_byte;
            eot_reg  <= end_of_text;
        end
    end

endmodule

// File: hw/rtl/stl_fifo.sv
// output record buffer: takes up to three records a cycle, gives one a cycle
// when out_stall is low; depends on stl_pkg
module stl_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  stl_pkg::rec_bundle_t wr,
    output logic                 room,
    output logic                 out_valid,
    input  logic                 out_stall,
    output stl_pkg::rec_t        head
);

    stl_pkg::rec_t mem_reg [stl_pkg::FIFO_DEPTH];
    logic [stl_pkg::PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [stl_pkg::PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [stl_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic pop;

    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign head      = mem_reg[rd_ptr_reg];
    // space for the largest burst one item can cause
    assign room      = cnt_reg <= stl_pkg::CNT_W'(stl_pkg::FIFO_DEPTH - stl_pkg::MAX_RECS);

    assign wr_ptr_next = wr_ptr_reg + stl_pkg::PTR_W'(wr.count);
    assign rd_ptr_next = rd_ptr_reg + stl_pkg::PTR_W'(pop);
    assign cnt_next    = cnt_reg + stl_pkg::CNT_W'(wr.count) - stl_pkg::CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < stl_pkg::MAX_RECS; k++)
        begin
            if (2'(k) < wr.count)
                mem_reg[wr_ptr_reg + stl_pkg::PTR_W'(k)] <= wr.recs[k];
        end
    end

endmodule
